/* src/tqm_pkg.sv */
// shared types and constants for the triangle quality measure
package tqm_pkg;

   localparam int ALPHA_BITS      = 19;
   localparam int ALPHA_FRAC_BITS = 16;
   localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 19'd227023;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ALPHA_IDX = 0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ALPHA_ADDR = CSR_ADDR_BITS'(4 * CSR_ALPHA_IDX);

   typedef struct packed {
      logic tri_valid;
      logic last;
   } ctl_type;

endpackage

/* src/tqm_geom.sv */
// edge vectors, doubled area, squared edge sum and alpha partial products
module tqm_geom #(
   parameter int COORD_BITS = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic                               in_valid,
   input  logic signed [COORD_BITS-1:0]       ax,
   input  logic signed [COORD_BITS-1:0]       ay,
   input  logic signed [COORD_BITS-1:0]       bx,
   input  logic signed [COORD_BITS-1:0]       by_coord,
   input  logic signed [COORD_BITS-1:0]       cx,
   input  logic signed [COORD_BITS-1:0]       cy,
   input  tqm_pkg::ctl_type                   in_ctl,
   input  logic [tqm_pkg::ALPHA_BITS-1:0]     alpha,
   output logic                               out_valid,
   output logic [tqm_pkg::ALPHA_BITS+COORD_BITS:0] out_plo,
   output logic [tqm_pkg::ALPHA_BITS+COORD_BITS:0] out_phi,
   output logic [2*COORD_BITS+2:0]            out_h,
   output logic                               out_dpos,
   output tqm_pkg::ctl_type                   out_ctl
);
   import tqm_pkg::*;

   localparam int DW   = COORD_BITS + 1;
   localparam int PW   = 2 * DW;
   localparam int SQW  = 2 * COORD_BITS + 1;
   localparam int AW   = 2 * COORD_BITS + 3;
   localparam int HAW  = 2 * COORD_BITS + 2;
   localparam int HW   = 2 * COORD_BITS + 3;
   localparam int LO_W = COORD_BITS + 1;
   localparam int DPW  = 2 * COORD_BITS + 2;
   localparam int PLW  = ALPHA_BITS + LO_W;

   logic [3:0] vld_ff;

   logic signed [DW-1:0] abx_ff, aby_ff, acx_ff, acy_ff, bcx_ff, bcy_ff;
   logic signed [PW-1:0] pab_ff, pba_ff;
   logic [SQW-1:0]       sq_ff [6];
   logic signed [AW-1:0] d_ff;
   logic [HAW-1:0]       ha_ff, hb_ff;
   logic [HW-1:0]        h_ff;
   logic                 dpos_ff;
   logic [PLW-1:0]       plo_ff, phi_ff;
   ctl_type              ctl_ff [4];

   logic signed [PW-1:0] pab_in, pba_in;
   logic signed [PW-1:0] sq_full [6];
   logic signed [AW-1:0] d_in;
   logic [HAW-1:0]       ha_in, hb_in;

   always_comb begin
      pab_in     = abx_ff * acy_ff;
      pba_in     = aby_ff * acx_ff;
      sq_full[0] = abx_ff * abx_ff;
      sq_full[1] = aby_ff * aby_ff;
      sq_full[2] = acx_ff * acx_ff;
      sq_full[3] = acy_ff * acy_ff;
      sq_full[4] = bcx_ff * bcx_ff;
      sq_full[5] = bcy_ff * bcy_ff;
      d_in       = AW'(pab_ff) - AW'(pba_ff);
      ha_in      = HAW'(sq_ff[0]) + HAW'(sq_ff[1]) + HAW'(sq_ff[2]);
      hb_in      = HAW'(sq_ff[3]) + HAW'(sq_ff[4]) + HAW'(sq_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         abx_ff    <= DW'(bx) - DW'(ax);
         aby_ff    <= DW'(by_coord) - DW'(ay);
         acx_ff    <= DW'(cx) - DW'(ax);
         acy_ff    <= DW'(cy) - DW'(ay);
         bcx_ff    <= DW'(cx) - DW'(bx);
         bcy_ff    <= DW'(cy) - DW'(by_coord);
         ctl_ff[0] <= in_ctl;

         pab_ff    <= pab_in;
         pba_ff    <= pba_in;
         for (int i = 0; i < 6; i++) begin
            sq_ff[i] <= sq_full[i][SQW-1:0];
         end
         ctl_ff[1] <= ctl_ff[0];

         d_ff      <= d_in;
         ha_ff     <= ha_in;
         hb_ff     <= hb_in;
         ctl_ff[2] <= ctl_ff[1];

         h_ff      <= HW'(ha_ff) + HW'(hb_ff);
         dpos_ff   <= !d_ff[AW-1] && (d_ff != '0);
         plo_ff    <= PLW'(alpha) * PLW'(d_ff[LO_W-1:0]);
         phi_ff    <= PLW'(alpha) * PLW'(d_ff[DPW-1:LO_W]);
         ctl_ff[3] <= ctl_ff[2];
      end
   end

   assign out_valid = vld_ff[3];
   assign out_plo   = plo_ff;
   assign out_phi   = phi_ff;
   assign out_h     = h_ff;
   assign out_dpos  = dpos_ff;
   assign out_ctl   = ctl_ff[3];

endmodule

/* src/tqm_div.sv */
// pipelined restoring divider, saturation and two-entry result buffer
module tqm_div #(
   parameter int COORD_BITS     = 24,
   parameter int QUAL_FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   output logic                               advance,
   input  logic                               in_valid,
   input  logic [tqm_pkg::ALPHA_BITS+COORD_BITS:0] in_plo,
   input  logic [tqm_pkg::ALPHA_BITS+COORD_BITS:0] in_phi,
   input  logic [2*COORD_BITS+2:0]            in_h,
   input  logic                               in_dpos,
   input  tqm_pkg::ctl_type                   in_ctl,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [QUAL_FRAC_BITS:0]            out_quality,
   output logic                               out_updated,
   output logic                               out_degenerate,
   output logic                               out_last
);
   import tqm_pkg::*;

   localparam int QB   = QUAL_FRAC_BITS;
   localparam int LO_W = COORD_BITS + 1;
   localparam int DPW  = 2 * COORD_BITS + 2;
   localparam int HW   = 2 * COORD_BITS + 3;
   localparam int QSH  = (QB > ALPHA_FRAC_BITS) ? QB - ALPHA_FRAC_BITS : 0;
   localparam int DSH  = (QB < ALPHA_FRAC_BITS) ? ALPHA_FRAC_BITS - QB : 0;
   localparam int NW   = ALPHA_BITS + DPW + QSH;
   localparam int DNW  = HW + DSH;
   localparam int RW   = (NW > DNW + QB + 3) ? NW : DNW + QB + 3;
   localparam int QW   = QB + 2;
   localparam int NS   = QB + 4;
   localparam int BW   = QB + 4;
   localparam logic [QB:0] ONE = (QB+1)'(1) << QB;

   logic [NS-1:0]  vld_ff;
   logic [RW-1:0]  rem_ff [NS];
   logic [DNW-1:0] den_ff [NS];
   logic [QW-1:0]  q_ff   [NS];
   logic           sat_ff [NS];
   logic           deg_ff [NS];
   ctl_type        ctl_ff [NS];

   logic [BW-1:0]  buf_ff [2];
   logic [1:0]     count_ff;

   logic [NW-1:0]  num_in;
   logic [BW-1:0]  res_in;
   logic [QB:0]    qual_in;
   logic           push, pop;

   assign advance = (count_ff != 2'd2);

   always_comb begin
      num_in = ((NW'(in_phi) << LO_W) + NW'(in_plo)) << QSH;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= RW'(num_in);
         den_ff[0] <= DNW'(in_h) << DSH;
         q_ff[0]   <= '0;
         sat_ff[0] <= 1'b0;
         deg_ff[0] <= !in_dpos || (in_h == '0);
         ctl_ff[0] <= in_ctl;

         rem_ff[1] <= rem_ff[0];
         den_ff[1] <= den_ff[0];
         q_ff[1]   <= '0;
         sat_ff[1] <= rem_ff[0] >= (RW'(den_ff[0]) << (QB + 2));
         deg_ff[1] <= deg_ff[0];
         ctl_ff[1] <= ctl_ff[0];
      end
   end

   for (genvar s = 2; s < NS; s++) begin : g_step
      localparam int K = NS - 1 - s;
      logic [RW-1:0] trial;
      logic          take;

      always_comb begin
         trial = RW'(den_ff[s-1]) << K;
         take  = rem_ff[s-1] >= trial;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s] <= take ? rem_ff[s-1] - trial : rem_ff[s-1];
            q_ff[s]   <= q_ff[s-1] | (take ? (QW'(1) << K) : '0);
            den_ff[s] <= den_ff[s-1];
            sat_ff[s] <= sat_ff[s-1];
            deg_ff[s] <= deg_ff[s-1];
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end
   end

   always_comb begin
      if (!ctl_ff[NS-1].tri_valid || deg_ff[NS-1]) begin
         qual_in = '0;
      end else if (sat_ff[NS-1] || (q_ff[NS-1] > QW'(ONE))) begin
         qual_in = ONE;
      end else begin
         qual_in = q_ff[NS-1][QB:0];
      end
      res_in = {ctl_ff[NS-1].last,
                ctl_ff[NS-1].tri_valid && deg_ff[NS-1],
                ctl_ff[NS-1].tri_valid,
                qual_in};
   end

   assign push = advance && vld_ff[NS-1];
   assign pop  = (count_ff != 2'd0) && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_ff + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (push && pop) begin
         buf_ff[0] <= res_in;
      end else if (pop) begin
         buf_ff[0] <= buf_ff[1];
      end else if (push) begin
         if (count_ff == 2'd0) begin
            buf_ff[0] <= res_in;
         end else begin
            buf_ff[1] <= res_in;
         end
      end
   end

   assign out_valid      = (count_ff != 2'd0);
   assign out_quality    = buf_ff[0][QB:0];
   assign out_updated    = buf_ff[0][QB+1];
   assign out_degenerate = buf_ff[0][QB+2];
   assign out_last       = buf_ff[0][QB+3];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> !push)
      else $error("result buffer overflow");

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_degenerate) |-> (out_quality == '0))
      else $error("degenerate triangle with nonzero quality");

   a_skip_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_updated) |-> (!out_degenerate && out_quality == '0))
      else $error("unused triangle carries a result");

   a_sat: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_quality <= ONE))
      else $error("quality above one");

endmodule

/* src/triangle_quality_measure.sv */
// top level: triangle quality measure with stream ports and register port
//
//  channel   dir   handshake              payload
//  req_      in    req_tvalid/req_tready  tdata ax..cy, tuser tri_valid, tlast last_in
//  rsp_      out   rsp_tvalid/rsp_tready  tdata quality, tuser updated/degenerate, tlast
//  csr_      in    psel/penable/pready    alpha_scale at address 0
//
//  one request per cycle unless both result buffer entries are taken; the divider
//  produces one quotient bit per stage
//  reset clears the valid bits and the result buffer, alpha_scale to its default
//  a two-entry result buffer keeps the pipe moving while one result waits;
//  the pipe holds only when both entries are taken
module triangle_quality_measure #(
   parameter int COORD_BITS     = 24,
   parameter int QUAL_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // ax, ay, bx, by_coord, cx, cy
   input  logic [((6*COORD_BITS+7)/8)*8-1:0]   req_tdata,
   // tri_valid
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // quality
   output logic [((QUAL_FRAC_BITS+8)/8)*8-1:0] rsp_tdata,
   // updated, degenerate
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tqm_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [tqm_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [tqm_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import tqm_pkg::*;

   localparam int CB    = COORD_BITS;
   localparam int QB    = QUAL_FRAC_BITS;
   localparam int OUT_W = ((QB + 8) / 8) * 8;
   localparam int PLW   = ALPHA_BITS + CB + 1;
   localparam int HW    = 2 * CB + 3;

   logic [ALPHA_BITS-1:0] alpha_ff;
   logic                  alpha_sel;
   logic                  advance;
   ctl_type               req_ctl, geom_ctl;
   logic                  geom_valid, geom_dpos;
   logic [PLW-1:0]        geom_plo, geom_phi;
   logic [HW-1:0]         geom_h;
   logic [QB:0]           quality;
   logic                  updated, degenerate;

   // word address decode, byte offset ignored
   assign alpha_sel = (csr_paddr[CSR_ADDR_BITS-1:2] == CSR_ALPHA_ADDR[CSR_ADDR_BITS-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && alpha_sel) begin
         alpha_ff <= csr_pwdata[ALPHA_BITS-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = alpha_sel ? CSR_DATA_BITS'(alpha_ff) : '0;

   assign req_ctl.tri_valid = req_tuser;
   assign req_ctl.last      = req_tlast;
   assign req_tready        = advance;

   tqm_geom #(
      .COORD_BITS(CB)
   ) u_geom (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_tvalid),
      .ax       (req_tdata[0*CB +: CB]),
      .ay       (req_tdata[1*CB +: CB]),
      .bx       (req_tdata[2*CB +: CB]),
      .by_coord (req_tdata[3*CB +: CB]),
      .cx       (req_tdata[4*CB +: CB]),
      .cy       (req_tdata[5*CB +: CB]),
      .in_ctl   (req_ctl),
      .alpha    (alpha_ff),
      .out_valid(geom_valid),
      .out_plo  (geom_plo),
      .out_phi  (geom_phi),
      .out_h    (geom_h),
      .out_dpos (geom_dpos),
      .out_ctl  (geom_ctl)
   );

   tqm_div #(
      .COORD_BITS    (CB),
      .QUAL_FRAC_BITS(QB)
   ) u_div (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (geom_valid),
      .in_plo        (geom_plo),
      .in_phi        (geom_phi),
      .in_h          (geom_h),
      .in_dpos       (geom_dpos),
      .in_ctl        (geom_ctl),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_quality   (quality),
      .out_updated   (updated),
      .out_degenerate(degenerate),
      .out_last      (rsp_tlast)
   );

   assign rsp_tdata = OUT_W'(quality);
   assign rsp_tuser = {degenerate, updated};

endmodule

/* bench/tqm_checker.sv */
// checker for the triangle quality measure: predicts results from accepted requests and compares
`timescale 1ns / 100ps
module tqm_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [143:0] req_tdata,
   input  logic         req_tuser,
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [23:0]  rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         rsp_tlast,
   input  logic [18:0]  alpha_now,
   output int           fail_count,
   output int           pending_count,
   output int           result_count,
   output int           degen_count,
   output int           sat_count
);
   typedef struct packed {
      logic [16:0] quality;
      logic        updated;
      logic        degenerate;
      logic        last;
   } quality_result;

   quality_result quality_queue[$];

   function automatic quality_result predict_quality(logic [143:0] d, logic valid,
                                                     logic last, logic [18:0] alpha);
      quality_result r;
      logic signed [63:0] ax, ay, bx, by, cx, cy, abx, aby, acx, acy, bcx, bcy;
      logic signed [127:0] area, hsum;
      logic [127:0] num, q;
      r = '0;
      r.last = last;
      if (valid) begin
         ax = 64'(signed'(d[23:0]));    ay = 64'(signed'(d[47:24]));
         bx = 64'(signed'(d[71:48]));   by = 64'(signed'(d[95:72]));
         cx = 64'(signed'(d[119:96]));  cy = 64'(signed'(d[143:120]));
         abx = bx - ax; aby = by - ay; acx = cx - ax; acy = cy - ay;
         bcx = cx - bx; bcy = cy - by;
         area = 128'(abx) * 128'(acy) - 128'(aby) * 128'(acx);
         hsum = 128'(abx) * 128'(abx) + 128'(aby) * 128'(aby) + 128'(acx) * 128'(acx)
              + 128'(acy) * 128'(acy) + 128'(bcx) * 128'(bcx) + 128'(bcy) * 128'(bcy);
         r.updated = 1'b1;
         if (area <= 0 || hsum == 0) begin
            r.degenerate = 1'b1;
         end else begin
            num = 128'(area) * {109'd0, alpha};
            q = num / 128'(hsum);
            r.quality = (q > 128'd65536) ? 17'd65536 : q[16:0];
         end
      end
      return r;
   endfunction

   assign pending_count = quality_queue.size();

   always @(posedge clock) begin
      quality_result got, want;
      if (reset) begin
         quality_queue.delete();
         fail_count <= 0;
         result_count <= 0;
         degen_count <= 0;
         sat_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            quality_queue.push_back(predict_quality(req_tdata, req_tuser, req_tlast,
                                                    alpha_now));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[16:0], rsp_tuser[0], rsp_tuser[1], rsp_tlast};
            result_count <= result_count + 1;
            if (got.degenerate) degen_count <= degen_count + 1;
            if (got.quality == 17'd65536) sat_count <= sat_count + 1;
            if (quality_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = quality_queue.pop_front();
               if (got != want || rsp_tdata[23:17] != 0) begin
                  if (fail_count < 10)
                     $display({"mismatch: expected q=%0d upd=%b deg=%b last=%b, ",
                               "got q=%0d upd=%b deg=%b last=%b"},
                              want.quality, want.updated, want.degenerate, want.last,
                              rsp_tdata, got.updated, got.degenerate, got.last);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

/* bench/tb_triangle_quality_measure.sv */
// testbench top: drives triangles and register writes into the quality measure and reports
`timescale 1ns / 100ps
module tb_triangle_quality_measure;
   import tqm_pkg::*;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0, req_tready;
   logic [143:0] req_tdata = '0;
   logic         req_tuser = 0, req_tlast = 0;
   logic         rsp_tvalid, rsp_tready = 0;
   logic [23:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0, csr_prdata;
   logic         csr_pready;
   logic [18:0]  alpha_now = ALPHA_RESET;
   int           fail_count, pending_count, result_count, degen_count, sat_count;
   int           stall_cycles = 0, sent = 0;
   bit           calm = 0;
   bit           timed_out = 0;

   localparam int STALL_LIMIT = 5000;

   always #2 clock = ~clock;

   triangle_quality_measure dut (.*);

   tqm_checker u_checker (.*);

   // random backpressure on results
   always @(posedge clock)
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 26);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles > STALL_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("watchdog expired");
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_alpha(logic [18:0] value);
      @(posedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_paddr <= CSR_ALPHA_ADDR;
      csr_pwdata <= {13'd0, value};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      alpha_now = value;
   endtask

   task automatic send_triangle(logic [23:0] ax, ay, bx, by, cx, cy, logic valid, last);
      while (!calm && $urandom_range(99) < 26) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {cy, cx, by, bx, ay, ax};
      req_tuser <= valid;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic drain;
      req_tvalid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [23:0] rand_coord(int span);
      if (span >= 24) return 24'($urandom);
      return 24'($signed($urandom_range((1 << span) - 1)) - (1 << (span - 1)));
   endfunction

   task automatic random_triangles(int count);
      int span;
      logic [23:0] x0, y0;
      for (int i = 0; i < count; i++) begin
         span = $urandom_range(2, 24);
         if ($urandom_range(9) < 2) begin
            // near-equilateral or collinear shapes around a random origin
            x0 = rand_coord(20); y0 = rand_coord(20);
            if ($urandom_range(1))
               send_triangle(x0, y0, x0 + 24'd1000, y0, x0 + 24'd500, y0 + 24'd866,
                             1'b1, 1'($urandom_range(1)));
            else
               send_triangle(x0, y0, x0 + 24'd7, y0 + 24'd3, x0 + 24'd14, y0 + 24'd6,
                             1'b1, 1'($urandom_range(1)));
         end else begin
            send_triangle(rand_coord(span), rand_coord(span), rand_coord(span),
                          rand_coord(span), rand_coord(span), rand_coord(span),
                          $urandom_range(9) != 0, 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      // directed requests
      send_triangle(0, 0, 1000, 0, 500, 866, 1, 0);
      send_triangle(0, 0, 500, 866, 1000, 0, 1, 0);
      send_triangle(5, 5, 5, 5, 5, 5, 1, 0);
      send_triangle(0, 0, 2, 2, 4, 4, 1, 0);
      send_triangle(0, 0, 1, 0, 0, 1, 1, 1);
      send_triangle(24'h800000, 24'h800000, 24'h7fffff, 24'h800000, 24'h800000,
                    24'h7fffff, 1, 0);
      send_triangle(24'h7fffff, 24'h7fffff, 24'h800000, 24'h7fffff, 24'h7fffff,
                    24'h800000, 1, 0);
      send_triangle(24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000, 24'h7fffff,
                    24'h7fffff, 1, 1);
      send_triangle(24'hffffff, 24'h555555, 24'haaaaaa, 24'h123456, 24'hedcba9, 0, 0, 1);
      send_triangle(0, 0, 24'h7fffff, 0, 0, 1, 1, 0);
      send_triangle(0, 0, 3, 0, 0, 24'h7fffff, 1, 1);
      drain();
      write_alpha(19'h7ffff);
      send_triangle(0, 0, 1000, 0, 500, 866, 1, 0);
      send_triangle(0, 0, 100, 0, 0, 100, 1, 1);
      random_triangles(150);
      drain();
      write_alpha(0);
      send_triangle(0, 0, 1000, 0, 500, 866, 1, 0);
      send_triangle(0, 0, 500, 866, 1000, 0, 1, 1);
      random_triangles(60);
      drain();
      write_alpha(19'd1);
      random_triangles(60);
      drain();
      write_alpha(ALPHA_RESET);
      calm = 1;
      random_triangles(150);
      calm = 0;
      random_triangles(200);
      drain();
      $display("sent %0d triangles, %0d results checked (%0d degenerate, %0d saturated)",
               sent, result_count, degen_count, sat_count);
      $display("alpha settings covered: default, max, zero and one");
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
